// ===== hw/rtl/ppu_pkg.sv =====
`default_nettype none
package ppu_pkg;

  localparam int SLOTS   = 1024;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int IN_W    = 256;
  localparam int OUT_W   = 112;
  localparam logic [63:0] SPEED_SQ_LIMIT = 64'd4294;

  localparam logic [15:0] WIDTH_RESET  = 16'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAWN,
    ST_TICK,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               live;
    logic [15:0]        life;
    logic [16:0]        ds;
    logic [16:0]        dv;
    logic signed [31:0] spin;
    logic signed [31:0] ang;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } entry_t;

  typedef struct packed {
    logic               accepted;
    logic [IDX_W-1:0]   slot_used;
    logic               is_active;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
  } result_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } axis_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [31:0] negate(input logic signed [31:0] v);
    negate = (v == S32_MIN) ? S32_MAX : -v;
  endfunction

  // Clamp into [0, wall] and reflect the velocity of a clamped axis.
  function automatic axis_t bounce(input logic signed [31:0] pos,
                                   input logic signed [31:0] vel,
                                   input logic [15:0] wall);
    axis_t r;
    logic signed [32:0] limit;
    r.pos = pos;
    r.vel = vel;
    limit = $signed({1'b0, wall, 16'h0000});
    if (pos[31]) begin
      r.pos = '0;
      r.vel = negate(vel);
    end else if ($signed({pos[31], pos}) > limit) begin
      r.pos = limit[31:0];
      r.vel = negate(vel);
    end
    bounce = r;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      sat34 = v[31:0];
    end else begin
      sat34 = v[33] ? S32_MIN : S32_MAX;
    end
  endfunction

  // Arithmetic shift floors the Q16 product before saturation.
  function automatic logic signed [31:0] damp_sat(input logic signed [49:0] p);
    logic signed [49:0] q;
    q = p >>> 16;
    damp_sat = sat34(q[33:0]);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? S32_MIN : S32_MAX;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/particle_pool_update.sv =====
// Particle pool with spawn, tick and slot read items.
// Input beats carry the opcode in in_tuser and the slot and particle fields
// in in_tdata. Each input beat gives exactly one output beat; out_tuser
// holds the accepted flag, out_tdata the slot and readback fields.
// All particle state sits in one 1024-entry memory with a registered read;
// the block works on one item at a time.
// Spawn: a pipelined next-fit scan reads one slot per cycle from the
// rotating pointer and stops at the first free slot.
// Tick: one slot enters the update pipeline per cycle, with writeback
// at the end of the pipeline.
// After reset the block runs a clearing pass over all 1024 memory entries,
// with in_tready low; the world size registers return to 640x480.
// Configuration writes are taken in any cycle through cfg_we.
// A finished result waits in the output register while out_tready is low;
// the next item is accepted meanwhile and its result waits in turn.
`default_nettype none
module particle_pool_update (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // slot, pos_x, pos_y, vel_x, vel_y, angle, spin, vel_damping,
  // spin_damping, lifetime, zero fill
  input  wire logic [ppu_pkg::IN_W-1:0]  in_tdata,
  // opcode
  input  wire logic [1:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // slot_used, is_active, out_pos_x, out_pos_y, out_angle, zero fill
  output logic [ppu_pkg::OUT_W-1:0]      out_tdata,
  // accepted
  output logic                           out_tuser,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_addr,
  input  wire logic [15:0]               cfg_wdata
);

  ppu_pkg::state_t state_r, state_nxt;
  ppu_pkg::entry_t mem [ppu_pkg::SLOTS];
  ppu_pkg::entry_t rd_data_r, wr_data;
  logic [ppu_pkg::IDX_W-1:0] rd_addr, wr_addr;
  logic rd_en, wr_en;

  logic [15:0] width_r, height_r;
  logic [ppu_pkg::IDX_W-1:0] next_slot_r, next_slot_nxt;
  logic [ppu_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ppu_pkg::IDX_W-1:0] ptr_r, ptr_nxt;
  logic [ppu_pkg::CNT_W-1:0] chk_cnt_r, chk_cnt_nxt;
  logic chk_v_r, chk_v_nxt;
  logic [ppu_pkg::IDX_W-1:0] chk_ptr_r, chk_ptr_nxt;
  ppu_pkg::entry_t item_r;
  ppu_pkg::result_t res_r, res_nxt, out_r;
  logic out_valid_r;

  // Tick pipeline.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [ppu_pkg::IDX_W-1:0] a1_r, a2_r, a3_r, a4_r, a5_r;
  ppu_pkg::entry_t s2_r, s3_r, s4_r, s5_r;
  ppu_pkg::entry_t s2_nxt, s4_nxt, s5_nxt;
  ppu_pkg::axis_t bx, by;
  logic signed [49:0] pvx_r, pvy_r, psp_r;
  logic [63:0] sqx_r, sqy_r;
  logic [31:0] ax, ay;
  logic [64:0] sq_sum;
  logic tick_busy;

  ppu_pkg::op_t in_op;
  ppu_pkg::entry_t in_entry;

  assign in_op = ppu_pkg::op_t'(in_tuser);
  assign in_entry.live = 1'b1;
  assign in_entry.px   = in_tdata[41:10];
  assign in_entry.py   = in_tdata[73:42];
  assign in_entry.vx   = in_tdata[105:74];
  assign in_entry.vy   = in_tdata[137:106];
  assign in_entry.ang  = in_tdata[169:138];
  assign in_entry.spin = in_tdata[201:170];
  assign in_entry.dv   = in_tdata[218:202];
  assign in_entry.ds   = in_tdata[235:219];
  assign in_entry.life = in_tdata[251:236];

  assign in_tready  = (state_r == ppu_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.accepted;
  assign out_tdata  = {5'b0, out_r.angle, out_r.pos_y, out_r.pos_x,
                       out_r.is_active, out_r.slot_used};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ppu_pkg::WIDTH_RESET;
      height_r <= ppu_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (ppu_pkg::reg_idx_t'(cfg_addr))
        ppu_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        ppu_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: bounce on the entry just read.
  assign bx = ppu_pkg::bounce(rd_data_r.px, rd_data_r.vx, width_r);
  assign by = ppu_pkg::bounce(rd_data_r.py, rd_data_r.vy, height_r);
  assign ax = ppu_pkg::abs32(s4_r.vx);
  assign ay = ppu_pkg::abs32(s4_r.vy);
  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign tick_busy = v1_r | v2_r | v3_r | v4_r | v5_r;

  always_comb begin
    s2_nxt      = rd_data_r;
    s2_nxt.px   = bx.pos;
    s2_nxt.vx   = bx.vel;
    s2_nxt.py   = by.pos;
    s2_nxt.vy   = by.vel;
    s4_nxt      = s3_r;
    s4_nxt.vx   = ppu_pkg::damp_sat(pvx_r);
    s4_nxt.vy   = ppu_pkg::damp_sat(pvy_r);
    s4_nxt.spin = ppu_pkg::damp_sat(psp_r);
    s5_nxt      = s4_r;
    s5_nxt.px   = ppu_pkg::sat_add(s4_r.px, s4_r.vx);
    s5_nxt.py   = ppu_pkg::sat_add(s4_r.py, s4_r.vy);
    s5_nxt.ang  = ppu_pkg::sat_add(s4_r.ang, s4_r.spin);
  end

  always_ff @(posedge clk) begin
    s2_r  <= s2_nxt;
    a2_r  <= a1_r;
    s3_r  <= s2_r;
    pvx_r <= s2_r.vx * $signed({1'b0, s2_r.dv});
    pvy_r <= s2_r.vy * $signed({1'b0, s2_r.dv});
    psp_r <= s2_r.spin * $signed({1'b0, s2_r.ds});
    a3_r  <= a2_r;
    s4_r  <= s4_nxt;
    a4_r  <= a3_r;
    s5_r  <= s5_nxt;
    sqx_r <= ax * ax;
    sqy_r <= ay * ay;
    a5_r  <= a4_r;
  end

  always_comb begin
    state_nxt     = state_r;
    next_slot_nxt = next_slot_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    chk_cnt_nxt   = chk_cnt_r;
    chk_v_nxt     = 1'b0;
    chk_ptr_nxt   = chk_ptr_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    unique case (state_r)
      ppu_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ppu_pkg::IDX_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ppu_pkg::CNT_W'(ppu_pkg::SLOTS - 1)) begin
          state_nxt = ppu_pkg::ST_IDLE;
        end
      end
      ppu_pkg::ST_IDLE: begin
        res_nxt = '0;
        if (in_tvalid) begin
          cnt_nxt     = '0;
          ptr_nxt     = next_slot_r;
          chk_cnt_nxt = '0;
          unique case (in_op)
            ppu_pkg::OP_SPAWN: state_nxt = ppu_pkg::ST_SPAWN;
            ppu_pkg::OP_TICK:  state_nxt = ppu_pkg::ST_TICK;
            ppu_pkg::OP_READ: begin
              rd_en       = 1'b1;
              rd_addr     = in_tdata[ppu_pkg::IDX_W-1:0];
              chk_ptr_nxt = in_tdata[ppu_pkg::IDX_W-1:0];
              state_nxt   = ppu_pkg::ST_READ;
            end
            default: state_nxt = ppu_pkg::ST_DONE;
          endcase
        end
      end
      ppu_pkg::ST_SPAWN: begin
        if (chk_v_r && !rd_data_r.live) begin
          wr_en   = 1'b1;
          wr_addr = chk_ptr_r;
          wr_data = item_r;
          next_slot_nxt = (chk_ptr_r == ppu_pkg::IDX_W'(ppu_pkg::SLOTS - 1)) ?
                          '0 : chk_ptr_r + 1'b1;
          res_nxt.accepted  = 1'b1;
          res_nxt.slot_used = chk_ptr_r;
          state_nxt = ppu_pkg::ST_DONE;
        end else if (chk_v_r &&
                     chk_cnt_r == ppu_pkg::CNT_W'(ppu_pkg::SLOTS - 1)) begin
          state_nxt = ppu_pkg::ST_DONE;
        end else begin
          chk_cnt_nxt = chk_v_r ? chk_cnt_r + 1'b1 : chk_cnt_r;
          if (cnt_r != ppu_pkg::CNT_W'(ppu_pkg::SLOTS)) begin
            rd_en       = 1'b1;
            rd_addr     = ptr_r;
            chk_v_nxt   = 1'b1;
            chk_ptr_nxt = ptr_r;
            cnt_nxt     = cnt_r + 1'b1;
            ptr_nxt     = (ptr_r == ppu_pkg::IDX_W'(ppu_pkg::SLOTS - 1)) ?
                          '0 : ptr_r + 1'b1;
          end
        end
      end
      ppu_pkg::ST_TICK: begin
        if (cnt_r != ppu_pkg::CNT_W'(ppu_pkg::SLOTS)) begin
          rd_en   = 1'b1;
          rd_addr = cnt_r[ppu_pkg::IDX_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else if (!tick_busy) begin
          res_nxt.accepted = 1'b1;
          state_nxt = ppu_pkg::ST_DONE;
        end
        if (v5_r && s5_r.live) begin
          wr_en   = 1'b1;
          wr_addr = a5_r;
          wr_data = s5_r;
          wr_data.live = !(s5_r.life == 16'd0 ||
                           sq_sum <= {1'b0, ppu_pkg::SPEED_SQ_LIMIT});
          wr_data.life = s5_r.life - 16'd1;
        end
      end
      ppu_pkg::ST_READ: begin
        res_nxt.accepted  = 1'b1;
        res_nxt.slot_used = chk_ptr_r;
        res_nxt.is_active = rd_data_r.live;
        res_nxt.pos_x     = rd_data_r.px;
        res_nxt.pos_y     = rd_data_r.py;
        res_nxt.angle     = rd_data_r.ang;
        state_nxt = ppu_pkg::ST_DONE;
      end
      ppu_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ppu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppu_pkg::ST_CLEAR;
      next_slot_r <= '0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      chk_cnt_r   <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_slot_r <= next_slot_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      chk_cnt_r   <= chk_cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      v1_r <= (state_r == ppu_pkg::ST_TICK) && rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (state_r == ppu_pkg::ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    chk_ptr_r <= chk_ptr_nxt;
    a1_r      <= rd_addr;
    if (state_r == ppu_pkg::ST_IDLE && in_tvalid) begin
      item_r <= in_entry;
    end
    if (state_r == ppu_pkg::ST_DONE && (!out_valid_r || out_tready)) begin
      out_r <= res_r;
    end
  end

endmodule
`default_nettype wire
